// ----- src/ksd_pkg.sv -----
// ksd_pkg: shared types, scan code constants and key tables for the
// keyboard scan code decoder. No dependencies; used by every module in src.
package ksd_pkg;

    // Result word kinds
    typedef enum logic [2:0] {
        K_CHAR  = 3'd0,
        K_KBD   = 3'd1,
        K_BEEP  = 3'd2,
        K_NACK  = 3'd3,
        K_STRAY = 3'd4
    } kind_t;

    // LED command handshake phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEFAULTS = 2'd1,
        PH_ED_ACK   = 2'd2,
        PH_LED_ACK  = 2'd3
    } phase_t;

    // Table select
    localparam logic [1:0] MAP_PLAIN = 2'd0;
    localparam logic [1:0] MAP_SHIFT = 2'd1;
    localparam logic [1:0] MAP_CTRL  = 2'd2;

    // Scan codes and bytes
    localparam logic [7:0] SC_BEEP_LO   = 8'h00;
    localparam logic [7:0] SC_BEEP_HI   = 8'hff;
    localparam logic [7:0] SC_ACK       = 8'hfa;
    localparam logic [7:0] SC_NACK      = 8'hfe;
    localparam logic [7:0] SC_CTRL_MK   = 8'h1d;
    localparam logic [7:0] SC_CTRL_BRK  = 8'h9d;
    localparam logic [7:0] SC_LSHIFT_MK = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BK = 8'hb6;
    localparam logic [7:0] SC_CAPS      = 8'h3a;
    localparam logic [7:0] SC_NUM       = 8'h45;
    localparam logic [7:0] SC_SCROLL    = 8'h46;
    localparam logic [7:0] MAP_LIMIT    = 8'h60;
    localparam logic [7:0] CMD_SET_LEDS = 8'hed;
    localparam logic [7:0] CHAR_ESC     = 8'h1b;
    localparam logic [7:0] NO_CHAR      = 8'hff;

    // Lock bit positions
    localparam logic [2:0] LOCK_SCROLL = 3'b001;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_CAPS   = 3'b100;

    localparam int MAP_DEPTH = 96;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } result_t;

    // Everything one scan byte produces: up to three result words
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     slot;
    } plan_t;

    localparam logic [7:0] KEYMAP_PLAIN [MAP_DEPTH] = '{
        8'o377, 8'o033, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066,
        8'o067, 8'o070, 8'o071, 8'o060, 8'o055, 8'o075, 8'o010, 8'o011,
        8'o161, 8'o167, 8'o145, 8'o162, 8'o164, 8'o171, 8'o165, 8'o151,
        8'o157, 8'o160, 8'o133, 8'o135, 8'o012, 8'o377, 8'o141, 8'o163,
        8'o144, 8'o146, 8'o147, 8'o150, 8'o152, 8'o153, 8'o154, 8'o073,
        8'o047, 8'o140, 8'o377, 8'o134, 8'o172, 8'o170, 8'o143, 8'o166,
        8'o142, 8'o156, 8'o155, 8'o054, 8'o056, 8'o057, 8'o377, 8'o052,
        8'o377, 8'o040, 8'o377, 8'o321, 8'o322, 8'o323, 8'o324, 8'o325,
        8'o326, 8'o327, 8'o330, 8'o331, 8'o332, 8'o377, 8'o377, 8'o310,
        8'o301, 8'o306, 8'o055, 8'o304, 8'o377, 8'o303, 8'o053, 8'o305,
        8'o302, 8'o307, 8'o311, 8'o177, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377
    };

    localparam logic [7:0] KEYMAP_SHIFT [MAP_DEPTH] = '{
        8'o377, 8'o033, 8'o041, 8'o100, 8'o043, 8'o044, 8'o045, 8'o136,
        8'o046, 8'o052, 8'o050, 8'o051, 8'o137, 8'o053, 8'o377, 8'o377,
        8'o121, 8'o127, 8'o105, 8'o122, 8'o124, 8'o131, 8'o125, 8'o111,
        8'o117, 8'o120, 8'o173, 8'o175, 8'o012, 8'o377, 8'o101, 8'o123,
        8'o104, 8'o106, 8'o107, 8'o110, 8'o112, 8'o113, 8'o114, 8'o072,
        8'o042, 8'o176, 8'o377, 8'o174, 8'o132, 8'o130, 8'o103, 8'o126,
        8'o102, 8'o116, 8'o115, 8'o074, 8'o076, 8'o077, 8'o377, 8'o052,
        8'o377, 8'o040, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o067,
        8'o070, 8'o071, 8'o055, 8'o064, 8'o065, 8'o066, 8'o053, 8'o061,
        8'o062, 8'o063, 8'o060, 8'o056, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377
    };

    localparam logic [7:0] KEYMAP_CTRL [MAP_DEPTH] = '{
        8'o377, 8'o377, 8'o377, 8'o000, 8'o377, 8'o377, 8'o377, 8'o036,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o037, 8'o377, 8'o377, 8'o377,
        8'o021, 8'o027, 8'o005, 8'o022, 8'o024, 8'o031, 8'o025, 8'o011,
        8'o017, 8'o020, 8'o033, 8'o035, 8'o012, 8'o377, 8'o001, 8'o023,
        8'o004, 8'o006, 8'o007, 8'o010, 8'o012, 8'o013, 8'o014, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o034, 8'o032, 8'o030, 8'o003, 8'o026,
        8'o002, 8'o016, 8'o015, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o000, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
        8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377
    };

    // Caps lock applies to these keys
    function automatic logic is_letter(input logic [6:0] code);
        is_letter = (code >= 7'h10 && code <= 7'h19) ||
                    (code >= 7'h1e && code <= 7'h26) ||
                    (code >= 7'h2c && code <= 7'h32);
    endfunction

    // Num lock applies to the keypad
    function automatic logic is_keypad(input logic [6:0] code);
        is_keypad = (code >= 7'h47 && code <= 7'h49) ||
                    (code >= 7'h4b && code <= 7'h4d) ||
                    (code >= 7'h4f && code <= 7'h53);
    endfunction

    // Caller keeps code below MAP_LIMIT
    function automatic logic [7:0] keymap_lookup(input logic [1:0] sel,
                                                 input logic [6:0] code);
        logic [7:0] ch;
        case (sel)
            MAP_PLAIN: ch = KEYMAP_PLAIN[code];
            MAP_SHIFT: ch = KEYMAP_SHIFT[code];
            MAP_CTRL:  ch = KEYMAP_CTRL[code];
            default:   ch = NO_CHAR;
        endcase
        keymap_lookup = ch;
    endfunction

endpackage

// ----- src/ksd_front.sv -----
// ksd_front: accepts scan bytes, keeps modifier, lock and LED handshake state,
// and turns each byte into a plan of up to three result words. Uses ksd_pkg.
module ksd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            q_full,
    input  logic [7:0]      scan_byte,
    input  logic            timeout_error,
    input  logic            parity_error,
    output logic            q_push,
    output ksd_pkg::plan_t  q_data
);

    logic                ctrl_reg, ctrl_next;
    logic                shift_reg, shift_next;
    logic [2:0]          lock_reg, lock_next;
    logic [2:0]          sent_reg, sent_next;
    logic                known_reg, known_next;
    ksd_pkg::phase_t     phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= 1'b0;
            shift_reg <= 1'b0;
            lock_reg  <= 3'd0;
            sent_reg  <= 3'd0;
            known_reg <= 1'b0;
            phase_reg <= ksd_pkg::PH_DEFAULTS;
        end
        else
        begin
            ctrl_reg  <= ctrl_next;
            shift_reg <= shift_next;
            lock_reg  <= lock_next;
            sent_reg  <= sent_next;
            known_reg <= known_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        logic            item_ok;
        logic [1:0]      n;
        logic [1:0]      sel;
        logic            flip;
        logic [7:0]      ch;
        ksd_pkg::plan_t  plan;

        ctrl_next  = ctrl_reg;
        shift_next = shift_reg;
        lock_next  = lock_reg;
        sent_next  = sent_reg;
        known_next = known_reg;
        phase_next = phase_reg;
        plan       = '0;
        n          = 2'd0;
        sel        = ksd_pkg::MAP_PLAIN;
        flip       = 1'b0;
        ch         = ksd_pkg::NO_CHAR;

        // bytes with a receive error are taken and dropped
        item_ok = push && !q_full && !timeout_error && !parity_error;

        if (item_ok)
        begin
            unique case (scan_byte) inside
                ksd_pkg::SC_BEEP_LO, ksd_pkg::SC_BEEP_HI:
                begin
                    plan.slot[n] = '{kind: ksd_pkg::K_BEEP, value: 8'h00};
                    n = n + 2'd1;
                end
                ksd_pkg::SC_ACK:
                begin
                    if (phase_reg == ksd_pkg::PH_ED_ACK)
                    begin
                        phase_next = ksd_pkg::PH_LED_ACK;
                        plan.slot[n] = '{kind: ksd_pkg::K_KBD, value: {5'd0, sent_reg}};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        if (phase_reg == ksd_pkg::PH_IDLE)
                        begin
                            plan.slot[n] = '{kind: ksd_pkg::K_STRAY, value: 8'h00};
                            n = n + 2'd1;
                        end
                        phase_next = ksd_pkg::PH_IDLE;
                    end
                end
                ksd_pkg::SC_NACK:
                begin
                    plan.slot[n] = '{kind: ksd_pkg::K_NACK, value: 8'h00};
                    n = n + 2'd1;
                    phase_next = ksd_pkg::PH_IDLE;
                end
                ksd_pkg::SC_CTRL_MK:  ctrl_next = 1'b1;
                ksd_pkg::SC_CTRL_BRK: ctrl_next = 1'b0;
                ksd_pkg::SC_LSHIFT_MK, ksd_pkg::SC_RSHIFT_MK: shift_next = 1'b1;
                ksd_pkg::SC_LSHIFT_BK, ksd_pkg::SC_RSHIFT_BK: shift_next = 1'b0;
                ksd_pkg::SC_CAPS:   lock_next = lock_reg ^ ksd_pkg::LOCK_CAPS;
                ksd_pkg::SC_NUM:    lock_next = lock_reg ^ ksd_pkg::LOCK_NUM;
                ksd_pkg::SC_SCROLL: lock_next = lock_reg ^ ksd_pkg::LOCK_SCROLL;
                default:
                begin
                    if (scan_byte < ksd_pkg::MAP_LIMIT)
                    begin
                        flip = ((|(lock_reg & ksd_pkg::LOCK_CAPS)) &&
                                ksd_pkg::is_letter(scan_byte[6:0])) ||
                               ((|(lock_reg & ksd_pkg::LOCK_NUM)) &&
                                ksd_pkg::is_keypad(scan_byte[6:0]));
                        if (ctrl_reg)
                            sel = ksd_pkg::MAP_CTRL;
                        else
                            sel = {1'b0, shift_reg ^ flip};
                        ch = ksd_pkg::keymap_lookup(sel, scan_byte[6:0]);
                        if (ch != ksd_pkg::NO_CHAR)
                        begin
                            // high-bit entries go out as an escape pair
                            if (ch[7])
                            begin
                                plan.slot[n] = '{kind: ksd_pkg::K_CHAR,
                                                 value: ksd_pkg::CHAR_ESC};
                                n = n + 2'd1;
                            end
                            plan.slot[n] = '{kind: ksd_pkg::K_CHAR, value: {1'b0, ch[6:0]}};
                            n = n + 2'd1;
                        end
                    end
                end
            endcase

            // start an LED update when the locks moved or none was sent yet, and no command is open
            if ((!known_reg || sent_reg != lock_next) && phase_next == ksd_pkg::PH_IDLE)
            begin
                sent_next  = lock_next;
                known_next = 1'b1;
                phase_next = ksd_pkg::PH_ED_ACK;
                plan.slot[n] = '{kind: ksd_pkg::K_KBD, value: ksd_pkg::CMD_SET_LEDS};
                n = n + 2'd1;
            end
        end

        plan.count = n;
        q_data     = plan;
        q_push     = item_ok && (n != 2'd0);
    end

endmodule

// ----- src/ksd_queue.sv -----
// ksd_queue: short register queue of result plans between front and back.
// Uses ksd_pkg for the plan type.
module ksd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ksd_pkg::plan_t  wr_data,
    output logic            full,
    input  logic            pop,
    output ksd_pkg::plan_t  rd_data,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ksd_pkg::plan_t  entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- src/ksd_back.sv -----
// ksd_back: takes plans from the queue and issues their result words one per
// cycle through an output register while it is free or popped. Uses ksd_pkg.
module ksd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ksd_pkg::plan_t  q_data,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [2:0]      kind,
    output logic [7:0]      value,
    output logic            last
);

    ksd_pkg::plan_t    plan_reg, plan_next;
    logic              plan_valid_reg, plan_valid_next;
    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    ksd_pkg::result_t  out_reg, out_next;
    logic              last_reg, last_next;

    logic              out_free, issue, slot_last;

    assign out_free  = !out_valid_reg || pop;
    assign issue     = plan_valid_reg && out_free;
    assign slot_last = (idx_reg + 2'd1) == plan_reg.count;
    assign q_pop     = !q_empty && (!plan_valid_reg || (issue && slot_last));

    always_comb
    begin
        plan_next       = plan_reg;
        plan_valid_next = plan_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        last_next       = last_reg;

        if (issue)
        begin
            out_valid_next = 1'b1;
            out_next       = plan_reg.slot[idx_reg];
            last_next      = slot_last;
            idx_next       = idx_reg + 2'd1;
            if (slot_last)
                plan_valid_next = 1'b0;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            plan_next       = q_data;
            plan_valid_next = 1'b1;
            idx_next        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign empty = !out_valid_reg;
    assign kind  = out_reg.kind;
    assign value = out_reg.value;
    assign last  = last_reg;

endmodule

// ----- src/keyboard_scancode_decoder_top.sv -----
// keyboard_scancode_decoder_top: PS/2 set-1 scan byte decoder with LED update
// handshake. Instantiates ksd_front, ksd_queue and ksd_back; uses ksd_pkg.
//
// Usage:
//   Input side is a queue write port: drive scan_byte with its timeout_error
//   and parity_error flags and raise push; the word is taken on a clock edge
//   with push high and full low. Bytes flagged with an error are taken and
//   dropped without results.
//   Output side is a queue read port: while empty is low, kind/value/last
//   show the oldest result word; it is taken on an edge with pop high.
//   One scan byte yields zero to three words (ESC prefix, character, LED
//   command byte); last marks the final word of a byte.
// Timing:
//   The front decodes and updates key state in the cycle a byte is taken, so
//   a new byte can be taken every cycle while the plan queue has room.
//   Plans pass the queue and the back end's plan register; the back end
//   issues one word per cycle to the output register while pop keeps up.
//   Sustained rate is set by the output side: words per byte, plus pop stalls.
// Stalls and reset:
//   When pop is held low the output register holds its word, the queue fills,
//   and full rises once QUEUE_DEPTH word-carrying bytes wait behind the back end.
//   Reset (rst_n low) empties the queue, clears modifiers and locks, and arms
//   the handshake to wait for the keyboard's defaults ack; the first ack or
//   nack after that starts an LED update.
module keyboard_scancode_decoder_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  scan_byte,
    input  logic        timeout_error,
    input  logic        parity_error,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic        last
);

    // front -> queue
    logic            fq_push;
    ksd_pkg::plan_t  fq_data;
    logic            q_full;

    // queue -> back
    logic            q_empty;
    logic            q_pop;
    ksd_pkg::plan_t  q_data;

    // input side stalls only on a full plan queue
    assign full = q_full;

    ksd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .q_full        (q_full),
        .scan_byte     (scan_byte),
        .timeout_error (timeout_error),
        .parity_error  (parity_error),
        .q_push        (fq_push),
        .q_data        (fq_data)
    );

    ksd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    ksd_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .kind    (kind),
        .value   (value),
        .last    (last)
    );

endmodule
